// File: rtl/core/rpfd_pkg.sv
// Shared types and constants for the rotated page framebuffer draw engine.
package rpfd_pkg;

  localparam int COORD_W     = 12;
  localparam int CNT_W       = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_FILL  = 3'd0,
    OP_PIXEL = 3'd1,
    OP_HLINE = 3'd2,
    OP_VLINE = 3'd3,
    OP_RECT  = 3'd4,
    OP_DIAG  = 3'd5,
    OP_READ  = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    JOB_FILL = 2'd0,
    JOB_DRAW = 2'd1,
    JOB_READ = 2'd2,
    JOB_NONE = 2'd3
  } job_kind_e;

  // One unit of back-end work: a fill, a read, a walk of cnt+1 pixels, or none.
  typedef struct packed {
    job_kind_e  kind;
    coord_t     x;
    coord_t     y;
    logic       dx_en;
    logic       dx_neg;
    logic       dy_en;
    logic       dy_neg;
    cnt_t       cnt;
    logic       pix_on;
    logic       last;
    logic [8:0] rd_index;
    logic       rd_oob;
  } job_t;

  function automatic coord_t sext10(logic [9:0] v);
    return {{(COORD_W-10){v[9]}}, v};
  endfunction

  function automatic coord_t sext9(logic [8:0] v);
    return {{(COORD_W-9){v[8]}}, v};
  endfunction

endpackage

// File: rtl/core/rpfd_front.sv
// Front end: takes commands, splits them into pixel walks, fills and reads.
module rpfd_front #(
  parameter int STORE_BYTES = 512
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            init_busy_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      in_op_i,
  input  logic [71:0]     in_data_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output rpfd_pkg::job_t  job_o
);

  logic                 hold_q, hold_d;
  logic [1:0]           sub_q, sub_d;
  rpfd_pkg::op_e        op_q;
  rpfd_pkg::coord_t     xs_q, ys_q, xe_q, ye_q, ex_q, ey_q;
  logic                 on_q;
  logic [8:0]           bi_q;

  rpfd_pkg::coord_t     xs_in, ys_in;
  logic                 accept, push;

  rpfd_pkg::coord_t     seg_a, seg_b, seg_f, diff, lo;
  logic                 seg_vert, neg;
  rpfd_pkg::cnt_t       span;

  assign in_ready_o  = !hold_q && !init_busy_i;
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = hold_q;
  assign push        = hold_q && job_ready_i;

  assign xs_in = rpfd_pkg::sext10(in_data_i[9:0]);
  assign ys_in = rpfd_pkg::sext10(in_data_i[19:10]);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= rpfd_pkg::op_e'(in_op_i);
      xs_q <= xs_in;
      ys_q <= ys_in;
      xe_q <= rpfd_pkg::sext10(in_data_i[29:20]);
      ye_q <= rpfd_pkg::sext10(in_data_i[39:30]);
      ex_q <= xs_in + rpfd_pkg::sext9(in_data_i[48:40]) - rpfd_pkg::coord_t'(1);
      ey_q <= ys_in + rpfd_pkg::sext9(in_data_i[57:49]) - rpfd_pkg::coord_t'(1);
      on_q <= in_data_i[58];
      bi_q <= in_data_i[67:59];
    end
  end

  always_comb begin
    hold_d = hold_q;
    sub_d  = sub_q;
    if (accept) begin
      hold_d = 1'b1;
      sub_d  = '0;
    end else if (push) begin
      sub_d = sub_q + 2'd1;
      if (job_o.last) begin
        hold_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      sub_q  <= '0;
    end else begin
      hold_q <= hold_d;
      sub_q  <= sub_d;
    end
  end

  // span endpoints of the current segment
  always_comb begin
    seg_a    = xs_q;
    seg_b    = xe_q;
    seg_f    = ys_q;
    seg_vert = 1'b0;
    case (op_q)
      rpfd_pkg::OP_VLINE: begin
        seg_a    = ys_q;
        seg_b    = ye_q;
        seg_f    = xs_q;
        seg_vert = 1'b1;
      end
      rpfd_pkg::OP_RECT: begin
        case (sub_q)
          2'd0: begin
            seg_b = ex_q;
          end
          2'd1: begin
            seg_b = ex_q;
            seg_f = ey_q;
          end
          2'd2: begin
            seg_a    = ys_q;
            seg_b    = ey_q;
            seg_f    = xs_q;
            seg_vert = 1'b1;
          end
          default: begin
            seg_a    = ys_q;
            seg_b    = ey_q;
            seg_f    = ex_q;
            seg_vert = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign diff = seg_b - seg_a;
  assign neg  = seg_b < seg_a;
  assign span = neg ? rpfd_pkg::cnt_t'(-diff) : rpfd_pkg::cnt_t'(diff);
  assign lo   = neg ? seg_b : seg_a;

  always_comb begin
    job_o          = '0;
    job_o.kind     = rpfd_pkg::JOB_DRAW;
    job_o.x        = xs_q;
    job_o.y        = ys_q;
    job_o.pix_on   = 1'b1;
    job_o.last     = (op_q != rpfd_pkg::OP_RECT) || (sub_q == 2'd3);
    job_o.rd_index = bi_q;
    job_o.rd_oob   = 32'(bi_q) >= STORE_BYTES;
    case (op_q)
      rpfd_pkg::OP_FILL: begin
        job_o.kind = rpfd_pkg::JOB_FILL;
      end
      rpfd_pkg::OP_PIXEL: begin
        job_o.pix_on = on_q;
      end
      rpfd_pkg::OP_HLINE, rpfd_pkg::OP_VLINE, rpfd_pkg::OP_RECT: begin
        job_o.cnt = span;
        if (seg_vert) begin
          job_o.x     = seg_f;
          job_o.y     = lo;
          job_o.dy_en = 1'b1;
        end else begin
          job_o.x     = lo;
          job_o.y     = seg_f;
          job_o.dx_en = 1'b1;
        end
      end
      rpfd_pkg::OP_DIAG: begin
        job_o.cnt    = span;
        job_o.dx_en  = 1'b1;
        job_o.dx_neg = neg;
        job_o.dy_en  = 1'b1;
        job_o.dy_neg = ye_q < ys_q;
      end
      rpfd_pkg::OP_READ: begin
        job_o.kind = rpfd_pkg::JOB_READ;
      end
      default: begin
        job_o.kind = rpfd_pkg::JOB_NONE;
      end
    endcase
  end

endmodule

// File: rtl/core/rpfd_queue.sv
// Short job queue between the front and back ends.
module rpfd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  rpfd_pkg::job_t  push_job_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output rpfd_pkg::job_t  pop_job_o
);

  localparam int PTR_W = $clog2(rpfd_pkg::QUEUE_DEPTH);

  rpfd_pkg::job_t        entry_q [rpfd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]        count_q, count_d;
  logic                  push, pop;

  assign push_ready_o = count_q != (PTR_W+1)'(rpfd_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

// File: rtl/core/rpfd_back.sv
// Back end: frame store, pixel walker with read-modify-write, fill and read.
module rpfd_back #(
  parameter int PHYS_WIDTH  = 128,
  parameter int PHYS_HEIGHT = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            top_msb_i,
  output logic            init_busy_o,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  rpfd_pkg::job_t  job_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_data_o,
  output logic            out_is_read_o
);

  localparam int PAGES       = (PHYS_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PHYS_WIDTH * PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int VIEW_W      = PHYS_HEIGHT;
  localparam int VIEW_H      = PHYS_WIDTH;

  typedef enum logic [7:0] {
    S_INIT = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_FILL = 8'b0000_0100,
    S_PIX  = 8'b0000_1000,
    S_WR   = 8'b0001_0000,
    S_RDA  = 8'b0010_0000,
    S_RDW  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [ADDR_W-1:0]     ptr_q, ptr_d;
  rpfd_pkg::job_t        cur_q;
  rpfd_pkg::coord_t      x_q, x_d, y_q, y_d, dxv, dyv;
  rpfd_pkg::cnt_t        cnt_q, cnt_d;
  logic [ADDR_W-1:0]     pix_addr_q;
  logic [7:0]            pix_mask_q, res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_data_q;
  logic                  out_is_read_q;

  logic [7:0]            mem [STORE_BYTES];
  logic [7:0]            rdata_q;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [7:0]            mem_wdata;

  logic                  in_view, walk_adv, load_out, last_ptr;
  logic [31:0]           pix_lin;
  logic [ADDR_W-1:0]     pix_addr;
  logic [2:0]            bit_idx;
  logic [7:0]            pix_mask;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign in_view = !x_q[rpfd_pkg::COORD_W-1] && (x_q < rpfd_pkg::coord_t'(VIEW_W))
                && !y_q[rpfd_pkg::COORD_W-1] && (y_q < rpfd_pkg::coord_t'(VIEW_H));
  // physical column is PHYS_WIDTH-1-y, physical row is x
  assign pix_lin  = 32'(x_q[rpfd_pkg::COORD_W-2:3]) * 32'(PHYS_WIDTH)
                  + 32'(PHYS_WIDTH - 1) - 32'(x_q[0] & 1'b0) - 32'(y_q[rpfd_pkg::COORD_W-2:0]);
  assign pix_addr = pix_lin[ADDR_W-1:0];
  assign bit_idx  = top_msb_i ? (3'd7 - x_q[2:0]) : x_q[2:0];
  assign pix_mask = 8'd1 << bit_idx;

  assign dxv = cur_q.dx_en ? (cur_q.dx_neg ? -rpfd_pkg::coord_t'(1) : rpfd_pkg::coord_t'(1))
                           : '0;
  assign dyv = cur_q.dy_en ? (cur_q.dy_neg ? -rpfd_pkg::coord_t'(1) : rpfd_pkg::coord_t'(1))
                           : '0;

  assign last_ptr    = ptr_q == ADDR_W'(STORE_BYTES - 1);
  assign job_ready_o = state_q == S_IDLE;
  assign init_busy_o = state_q == S_INIT;
  assign load_out    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    x_d       = x_q;
    y_d       = y_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = rpfd_pkg::FILL_BYTE;
    mem_raddr = pix_addr;
    walk_adv  = 1'b0;
    case (state_q)
      S_INIT, S_FILL: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + 1'b1;
        if (last_ptr) begin
          ptr_d   = '0;
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (job_valid_i) begin
          x_d   = job_i.x;
          y_d   = job_i.y;
          cnt_d = job_i.cnt;
          res_d = '0;
          ptr_d = '0;
          case (job_i.kind)
            rpfd_pkg::JOB_FILL: state_d = S_FILL;
            rpfd_pkg::JOB_DRAW: state_d = S_PIX;
            rpfd_pkg::JOB_READ: state_d = job_i.rd_oob ? S_DONE : S_RDA;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_PIX: begin
        if (in_view) begin
          state_d = S_WR;
        end else begin
          walk_adv = 1'b1;
        end
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pix_addr_q;
        mem_wdata = cur_q.pix_on ? (rdata_q & ~pix_mask_q) : (rdata_q | pix_mask_q);
        walk_adv  = 1'b1;
      end
      S_RDA: begin
        mem_raddr = ADDR_W'(cur_q.rd_index);
        state_d   = S_RDW;
      end
      S_RDW: begin
        res_d   = rdata_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (walk_adv) begin
      if (cnt_q == '0) begin
        state_d = cur_q.last ? S_DONE : S_IDLE;
      end else begin
        cnt_d   = cnt_q - 1'b1;
        x_d     = x_q + dxv;
        y_d     = y_q + dyv;
        state_d = S_PIX;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
    if (state_q == S_IDLE && job_valid_i) begin
      cur_q <= job_i;
    end
    if (state_q == S_PIX) begin
      pix_addr_q <= pix_addr;
      pix_mask_q <= pix_mask;
    end
    if (load_out) begin
      out_data_q    <= res_q;
      out_is_read_q <= cur_q.kind == rpfd_pkg::JOB_READ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_data_q;
  assign out_is_read_o = out_is_read_q;

  a_no_pop_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !(job_ready_o && job_valid_i))
    else $error("job taken during store clearing pass");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> ($past(state_q) == S_PIX))
    else $error("pixel write without preceding read");

  a_walk_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR && cnt_q != '0) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("walk counter did not step");

  a_done_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDW) |=> (state_q == S_DONE))
    else $error("read result not delivered");

endmodule

// File: rtl/core/rotated_page_framebuffer_draw_top.sv
// Top level of the rotated page framebuffer draw engine.
// Portrait drawing engine over a page-tiled monochrome store of
// PHYS_WIDTH*ceil(PHYS_HEIGHT/8) bytes; each command returns one transfer on
// the master side (read byte, or zero). After reset a clearing pass writes
// 0xFF to every store byte, one per cycle, and no command is taken until it
// ends. Commands are split by the front end into pixel walks that wait in a
// four-entry queue; a command is registered in the front end before its first
// walk reaches the queue. The back end does a read-modify-write on its store,
// which has separate read and write ports: a visible pixel is read in S_PIX and
// written in S_WR, a clipped pixel only passes S_PIX. A fill writes every store
// byte in turn; a read passes S_RDA and S_RDW, or goes straight to S_DONE when
// the byte index lies past the store. A rectangle is four walks. The user must
// write the bit-order register (top pixel of a page in bit 7 when set) on the
// cfg channel while no command is in flight; the block does not enforce this.
module rotated_page_framebuffer_draw_top #(
  parameter int PHYS_WIDTH  = 128,
  parameter int PHYS_HEIGHT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_start, y_start, x_end, y_end, rect_width, rect_height, pixel_on, byte_index
  input  logic [71:0] s_axis_tdata,
  // operation
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data
  output logic [7:0]  m_axis_tdata,
  // is_read
  output logic        m_axis_tuser
);

  localparam int STORE_BYTES = PHYS_WIDTH * ((PHYS_HEIGHT + 7) / 8);

  logic            top_msb_q;
  logic            init_busy;
  logic            fq_valid, fq_ready, qb_valid, qb_ready;
  rpfd_pkg::job_t  fq_job, qb_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_msb_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      top_msb_q <= cfg_data_i;
    end
  end

  rpfd_front #(
    .STORE_BYTES (STORE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_busy_i (init_busy),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready),
    .job_o       (fq_job)
  );

  rpfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_job_i   (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_job_o    (qb_job)
  );

  rpfd_back #(
    .PHYS_WIDTH  (PHYS_WIDTH),
    .PHYS_HEIGHT (PHYS_HEIGHT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .top_msb_i     (top_msb_q),
    .init_busy_o   (init_busy),
    .job_valid_i   (qb_valid),
    .job_ready_o   (qb_ready),
    .job_i         (qb_job),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_is_read_o (m_axis_tuser)
  );

endmodule

// File: tb/rpfd_checker.sv
`timescale 1ns / 100ps
// Checker for the draw engine: tracks the store image and compares every result transfer.
module rpfd_checker #(
  parameter int PHYS_WIDTH  = 128,
  parameter int PHYS_HEIGHT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [71:0] s_tdata_i,
  input  logic [2:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,
  input  logic        m_tuser_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  localparam int STORE_BYTES = PHYS_WIDTH * ((PHYS_HEIGHT + 7) / 8);

  typedef struct packed {
    logic [7:0] read_data;
    logic       is_read;
  } reply_t;

  logic [7:0] frame_mem [STORE_BYTES];
  logic       top_msb_q;
  reply_t     expected_replies [$];
  int         mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // logical (x,y) lands on physical column PHYS_WIDTH-1-y, row x
  function automatic void plot_pixel(int x, int y, logic lit);
    int row;
    int addr;
    int bit_pos;
    if (x < 0 || x >= PHYS_HEIGHT || y < 0 || y >= PHYS_WIDTH) return;
    row     = x;
    addr    = (row / 8) * PHYS_WIDTH + (PHYS_WIDTH - 1 - y);
    bit_pos = top_msb_q ? 7 - (row % 8) : row % 8;
    frame_mem[addr][bit_pos] = ~lit;
  endfunction

  function automatic void draw_row(int a, int b, int y);
    int t;
    int x;
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    for (x = a; x <= b; x++) plot_pixel(x, y, 1'b1);
  endfunction

  function automatic void draw_column(int x, int a, int b);
    int t;
    int y;
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    for (y = a; y <= b; y++) plot_pixel(x, y, 1'b1);
  endfunction

  function automatic reply_t apply_command(rpfd_pkg::op_e op, logic [71:0] f);
    int xs, ys, xe, ye, w, h, idx;
    int sx, sy, len, i;
    reply_t r;
    xs  = $signed(f[9:0]);
    ys  = $signed(f[19:10]);
    xe  = $signed(f[29:20]);
    ye  = $signed(f[39:30]);
    w   = $signed(f[48:40]);
    h   = $signed(f[57:49]);
    idx = f[67:59];
    r   = '0;
    case (op)
      rpfd_pkg::OP_FILL: begin
        foreach (frame_mem[k]) frame_mem[k] = rpfd_pkg::FILL_BYTE;
      end
      rpfd_pkg::OP_PIXEL: plot_pixel(xs, ys, f[58]);
      rpfd_pkg::OP_HLINE: draw_row(xs, xe, ys);
      rpfd_pkg::OP_VLINE: draw_column(xs, ys, ye);
      rpfd_pkg::OP_RECT: begin
        draw_row(xs, xs + w - 1, ys);
        draw_row(xs, xs + w - 1, ys + h - 1);
        draw_column(xs, ys, ys + h - 1);
        draw_column(xs + w - 1, ys, ys + h - 1);
      end
      rpfd_pkg::OP_DIAG: begin
        sx  = (xe >= xs) ? 1 : -1;
        sy  = (ye >= ys) ? 1 : -1;
        len = (xe >= xs) ? xe - xs : xs - xe;
        for (i = 0; i <= len; i++) plot_pixel(xs + i * sx, ys + i * sy, 1'b1);
      end
      rpfd_pkg::OP_READ: begin
        r.is_read = 1'b1;
        if (idx < STORE_BYTES) r.read_data = frame_mem[idx];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      foreach (frame_mem[k]) frame_mem[k] = rpfd_pkg::FILL_BYTE;
      top_msb_q = 1'b0;
      expected_replies.delete();
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer data %02h is_read %0b",
                                    m_tdata_i, m_tuser_i));
        end else begin
          want = expected_replies.pop_front();
          if (m_tdata_i !== want.read_data)
            report_mismatch($sformatf("read_data %02h, expected %02h",
                                      m_tdata_i, want.read_data));
          if (m_tuser_i !== want.is_read)
            report_mismatch($sformatf("is_read %0b, expected %0b",
                                      m_tuser_i, want.is_read));
        end
      end
      if (cfg_valid_i && cfg_ready_i) top_msb_q = cfg_data_i;
      if (s_tvalid_i && s_tready_i)
        expected_replies.push_back(apply_command(rpfd_pkg::op_e'(s_tuser_i), s_tdata_i));
      pending_o <= expected_replies.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for the draw engine: command and config stimulus, result stalls, verdict.
module tb;

  localparam int PHYS_WIDTH    = 128;
  localparam int PHYS_HEIGHT   = 32;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 150;
  localparam int CYCLE_LIMIT   = 20_000_000;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i    = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;

  int mismatch_count;
  int pending;
  int cycles  = 0;
  bit no_idle = 1'b0;

  rotated_page_framebuffer_draw_top #(
    .PHYS_WIDTH  (PHYS_WIDTH),
    .PHYS_HEIGHT (PHYS_HEIGHT)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  rpfd_checker #(
    .PHYS_WIDTH  (PHYS_WIDTH),
    .PHYS_HEIGHT (PHYS_HEIGHT)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tuser_i        (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // tdata, low bit up: x_start, y_start, x_end, y_end, rect_width, rect_height,
  // pixel_on, byte_index, zero pad
  function automatic logic [71:0] pack_fields(int xs, int ys, int xe, int ye,
                                              int w, int h, int on, int bi);
    return {4'b0, bi[8:0], on[0], h[8:0], w[8:0], ye[9:0], xe[9:0], ys[9:0], xs[9:0]};
  endfunction

  task automatic send_command(rpfd_pkg::op_e op, logic [71:0] fields);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= fields;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_top_msb(bit value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_command();
    int            pick, xs, ys, xe, ye, w, h, bi, on;
    bit            wide;
    rpfd_pkg::op_e op;
    pick = $urandom_range(0, 99);
    if (pick < 3) op = rpfd_pkg::OP_FILL;
    else if (pick < 23) op = rpfd_pkg::OP_PIXEL;
    else if (pick < 36) op = rpfd_pkg::OP_HLINE;
    else if (pick < 49) op = rpfd_pkg::OP_VLINE;
    else if (pick < 60) op = rpfd_pkg::OP_RECT;
    else if (pick < 72) op = rpfd_pkg::OP_DIAG;
    else if (pick < 98) op = rpfd_pkg::OP_READ;
    else op = rpfd_pkg::OP_NONE;
    // mostly short shapes around the view, now and then full-range fields
    wide = ($urandom_range(0, 24) == 0);
    if (wide) begin
      xs = $urandom_range(0, 1023) - 512;
      ys = $urandom_range(0, 1023) - 512;
      xe = $urandom_range(0, 1023) - 512;
      ye = $urandom_range(0, 1023) - 512;
      w  = $urandom_range(0, 511) - 256;
      h  = $urandom_range(0, 511) - 256;
    end else begin
      xs = $urandom_range(0, 39) - 4;
      ys = $urandom_range(0, 135) - 4;
      xe = xs + $urandom_range(0, 80) - 40;
      ye = ys + $urandom_range(0, 80) - 40;
      w  = $urandom_range(0, 46) - 6;
      h  = $urandom_range(0, 46) - 6;
    end
    bi = $urandom_range(0, 511);
    on = $urandom_range(0, 1);
    send_command(op, pack_fields(xs, ys, xe, ye, w, h, on, bi));
  endtask

  initial begin
    int hold;
    @(posedge clk_i);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    int ph;
    int n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_top_msb(1'b1);
    send_command(rpfd_pkg::OP_READ,  pack_fields(0, 0, 0, 0, 0, 0, 0, 0));
    send_command(rpfd_pkg::OP_READ,  pack_fields(0, 0, 0, 0, 0, 0, 0, 511));
    send_command(rpfd_pkg::OP_PIXEL, pack_fields(0, 0, 0, 0, 0, 0, 1, 0));
    send_command(rpfd_pkg::OP_PIXEL, pack_fields(31, 127, 0, 0, 0, 0, 1, 0));
    send_command(rpfd_pkg::OP_PIXEL, pack_fields(31, 127, 0, 0, 0, 0, 0, 0));
    send_command(rpfd_pkg::OP_PIXEL, pack_fields(-512, -512, 0, 0, 0, 0, 1, 0));
    send_command(rpfd_pkg::OP_PIXEL, pack_fields(511, 511, 0, 0, 0, 0, 1, 0));
    send_command(rpfd_pkg::OP_PIXEL, pack_fields(32, 128, 0, 0, 0, 0, 1, 0));
    send_command(rpfd_pkg::OP_HLINE, pack_fields(40, 3, -5, 0, 0, 0, 0, 0));
    send_command(rpfd_pkg::OP_VLINE, pack_fields(7, 200, 0, -3, 0, 0, 0, 0));
    send_command(rpfd_pkg::OP_RECT,  pack_fields(2, 10, 0, 0, 5, 4, 0, 0));
    send_command(rpfd_pkg::OP_RECT,  pack_fields(10, 20, 0, 0, 0, 0, 0, 0));
    send_command(rpfd_pkg::OP_RECT,  pack_fields(511, 511, 0, 0, -256, -256, 0, 0));
    send_command(rpfd_pkg::OP_RECT,  pack_fields(-512, -512, 0, 0, 255, 255, 0, 0));
    send_command(rpfd_pkg::OP_DIAG,  pack_fields(0, 0, 31, 31, 0, 0, 0, 0));
    send_command(rpfd_pkg::OP_DIAG,  pack_fields(31, 100, 0, 90, 0, 0, 0, 0));
    send_command(rpfd_pkg::OP_DIAG,  pack_fields(-512, 0, 511, 0, 0, 0, 0, 0));
    send_command(rpfd_pkg::OP_HLINE, pack_fields(-512, 64, 511, 0, 0, 0, 0, 0));
    send_command(rpfd_pkg::OP_VLINE, pack_fields(16, -512, 0, 511, 0, 0, 0, 0));
    send_command(rpfd_pkg::OP_READ,  pack_fields(0, 0, 0, 0, 0, 0, 0, 127));
    send_command(rpfd_pkg::OP_READ,  pack_fields(0, 0, 0, 0, 0, 0, 0, 383));
    send_command(rpfd_pkg::OP_NONE,  pack_fields(-1, -1, -1, -1, -1, -1, 1, 511));
    send_command(rpfd_pkg::OP_FILL,  pack_fields(0, 0, 0, 0, 0, 0, 0, 0));
    send_command(rpfd_pkg::OP_READ,  pack_fields(0, 0, 0, 0, 0, 0, 0, 127));

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      write_top_msb(ph[0]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_random_command();
      end
    end
    wait_idle();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
